// File: src/bufu_pkg.sv
package bufu_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int LEVEL_W    = 5;

    typedef logic [7:0]       t_byte;
    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_byte CH_CR = 8'h0D;
    localparam t_byte CH_LF = 8'h0A;

    localparam t_cnt CNT_FULL  = CNT_W'(FIFO_DEPTH);
    localparam t_cnt CNT_ROOM2 = CNT_W'(FIFO_DEPTH - 2);

    typedef enum logic [1:0] {
        OP_RECV  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_TXRDY = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH2,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic  push;
        logic  pop;
        t_byte wdata;
    } t_fifo_req;

    typedef struct packed {
        t_byte read_data;
        logic  read_valid;
        t_byte line_data;
        logic  line_valid;
        logic  accepted;
        logic  recv_notify;
    } t_result;

    function automatic t_ptr next_ptr(input t_ptr ptr);
        t_ptr res;
        if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

endpackage

// File: src/bufu_if.sv
interface bufu_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface bufu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] line_data;
    logic       line_valid;
    logic       accepted;
    logic       recv_notify;
    logic [4:0] rx_level;
    logic [4:0] tx_level;

    modport source (output valid, output read_data, output read_valid, output line_data,
                    output line_valid, output accepted, output recv_notify,
                    output rx_level, output tx_level, input ready);
    modport sink   (input valid, input read_data, input read_valid, input line_data,
                    input line_valid, input accepted, input recv_notify,
                    input rx_level, input tx_level, output ready);
endinterface

interface bufu_cfg_if;
    logic valid;
    logic ready;
    logic echo_enable;

    modport source (output valid, output echo_enable, input ready);
    modport sink   (input valid, input echo_enable, output ready);
endinterface

// File: src/bufu_ram.sv
module bufu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bufu_fifo.sv
module bufu_fifo import bufu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_fifo_req i_req,
    output t_byte     o_rdata,
    output t_cnt      o_count
);

    t_ptr r_head, n_head;
    t_ptr r_tail, n_tail;
    t_cnt r_count, n_count;

    // read port always looks at the head; its data is registered, so a popped byte lands in the cycle after the pop
    bufu_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.push),
        .i_waddr (r_tail),
        .i_wdata (i_req.wdata),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    always_comb begin
        n_head  = i_req.pop  ? next_ptr(r_head) : r_head;
        n_tail  = i_req.push ? next_ptr(r_tail) : r_tail;
        n_count = r_count;
        case ({i_req.push, i_req.pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// File: src/buffered_uart_fifo_with_echo_core.sv
// Serial port byte buffer: a receive FIFO and a transmit FIFO, FIFO_DEPTH
// bytes each, held in two single-port-read RAMs.
// i_req carries one request (operation, data_byte): line byte received,
// host write, host read or transmitter ready. o_rsp returns exactly one
// result per request with the popped bytes, the status flags and both
// FIFO levels after the request. i_cfg writes echo_enable and is always ready.
// Steps: the request is taken in the idle step and executed in the execute
// step; then a pop reads the RAM in the read step, or a CR LF push writes
// the LF in the second push step, before the emit step hands the result on.
// The sequencer takes one request at a time, so a new request is accepted
// only after the last one has left the emit step.
// Reset clears both FIFO pointers and counts, echo_enable and the result
// valid flag; the RAM contents stay undefined and are never read unwritten.
// When the receiver stalls o_rsp, the result register holds; a finished
// request waits in the emit step, and i_req is ready again once the
// result register has moved it out.
module buffered_uart_fifo_with_echo_core import bufu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bufu_req_if.sink    i_req,
    bufu_rsp_if.source  o_rsp,
    bufu_cfg_if.sink    i_cfg
);

    t_state    r_state, n_state;
    t_op       r_op;
    t_byte     r_byte;
    t_result   r_res, n_res;
    logic      r_echo;

    logic      r_out_valid;
    t_result   r_out;
    t_cnt      r_out_rx_cnt;
    t_cnt      r_out_tx_cnt;

    t_fifo_req rx_req, tx_req;
    t_byte     rx_rdata, tx_rdata;
    t_cnt      rx_count, tx_count;

    logic      w_rx_room;
    logic      w_tx_room1;
    logic      w_tx_room2;
    logic      w_echo_on;
    t_byte     w_tx_byte;
    logic      w_tx_is_lf;
    logic      w_tx_go;
    logic      w_pop_rx;
    logic      w_pop_tx;
    logic      w_emit;

    bufu_fifo u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rx_req),
        .o_rdata (rx_rdata),
        .o_count (rx_count)
    );

    bufu_fifo u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .o_rdata (tx_rdata),
        .o_count (tx_count)
    );

    // --- request decode, valid in the execute step ---
    always_comb begin
        w_rx_room  = (rx_count != CNT_FULL);
        w_tx_room1 = (tx_count != CNT_FULL);
        w_tx_room2 = (tx_count <= CNT_ROOM2);
        // echo only a byte that really goes into the receive FIFO
        w_echo_on  = (r_op == OP_RECV) && w_rx_room && r_echo;
        // echoed CR turns into LF, which then expands to CR LF like a host LF
        w_tx_byte  = ((r_op == OP_RECV) && (r_byte == CH_CR)) ? CH_LF : r_byte;
        w_tx_is_lf = (w_tx_byte == CH_LF);
        // all or nothing: an LF needs two free slots
        w_tx_go    = (w_echo_on || (r_op == OP_WRITE))
                   && (w_tx_is_lf ? w_tx_room2 : w_tx_room1);
        w_pop_rx   = (r_op == OP_READ)  && (rx_count != '0);
        w_pop_tx   = (r_op == OP_TXRDY) && (tx_count != '0);
        // hand over to the result register when it is free or being drained
        w_emit     = !r_out_valid || o_rsp.ready;
    end

    // --- sequencer: next state ---
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_tx_go && w_tx_is_lf) begin
                    n_state = S_PUSH2;
                end else if (w_pop_rx || w_pop_tx) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PUSH2: n_state = S_EMIT;
            S_READ:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // --- sequencer: FIFO requests and result build-up ---
    // Push and pop never share a cycle on one FIFO, so a popped entry is never
    // written in the same cycle as it is read.
    always_comb begin
        i_req.ready = 1'b0;
        rx_req      = '0;
        tx_req      = '0;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                n_res       = '0;
            end
            S_EXEC: begin
                if ((r_op == OP_RECV) && w_rx_room) begin
                    rx_req.push       = 1'b1;
                    rx_req.wdata      = r_byte;
                    n_res.accepted    = 1'b1;
                    n_res.recv_notify = 1'b1;
                end
                if (w_tx_go) begin
                    tx_req.push  = 1'b1;
                    tx_req.wdata = w_tx_is_lf ? CH_CR : w_tx_byte;
                    if (r_op == OP_WRITE) begin
                        n_res.accepted = 1'b1;
                    end
                end
                rx_req.pop = w_pop_rx;
                tx_req.pop = w_pop_tx;
            end
            S_PUSH2: begin
                // second half of the CR LF pair
                tx_req.push  = 1'b1;
                tx_req.wdata = CH_LF;
            end
            S_READ: begin
                if (r_op == OP_READ) begin
                    n_res.read_data  = rx_rdata;
                    n_res.read_valid = 1'b1;
                end else begin
                    n_res.line_data  = tx_rdata;
                    n_res.line_valid = 1'b1;
                end
            end
            S_EMIT: begin
                n_res = r_res;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_echo      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_echo <= i_cfg.echo_enable;
            end
            if ((r_state == S_EMIT) && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold the request, build the result, load the output
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op   <= t_op'(i_req.operation);
            r_byte <= i_req.data_byte;
        end
        r_res <= n_res;
        if ((r_state == S_EMIT) && w_emit) begin
            r_out        <= r_res;
            r_out_rx_cnt <= rx_count;
            r_out_tx_cnt <= tx_count;
        end
    end

    assign i_cfg.ready       = 1'b1;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out.read_data;
    assign o_rsp.read_valid  = r_out.read_valid;
    assign o_rsp.line_data   = r_out.line_data;
    assign o_rsp.line_valid  = r_out.line_valid;
    assign o_rsp.accepted    = r_out.accepted;
    assign o_rsp.recv_notify = r_out.recv_notify;
    assign o_rsp.rx_level    = LEVEL_W'(r_out_rx_cnt);
    assign o_rsp.tx_level    = LEVEL_W'(r_out_tx_cnt);

`ifndef ASSERT_OFF
    a_rx_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_req.push |-> (rx_count != CNT_FULL))
        else $error("push into full receive FIFO");

    a_tx_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_req.pop |=> (tx_count == CNT_W'($past(tx_count) - 1'b1)))
        else $error("transmit pop did not drop the level by one");

    a_lf_follows_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH2) |-> ($past(tx_req.push) && ($past(tx_req.wdata) == CH_CR)))
        else $error("LF pushed without a CR just before it");

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.read_valid && o_rsp.line_valid)
                        && !(o_rsp.recv_notify && !o_rsp.accepted))
        else $error("inconsistent result flags");
`endif

endmodule
